FILE: rtl/rcst_pkg.sv
// Shared constants and word types for the shared segment table.
package rcst_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int COUNT_BITS    = 8;
  localparam int KEY_W         = 32;
  localparam int PAGE_W        = 20;

  // table index and scan counter (the counter also holds TABLE_ENTRIES)
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCN_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic CMD_OPEN  = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  seg_key;
    logic              spare_page_valid;
    logic [PAGE_W-1:0] spare_page;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] page_out;
    logic              page_taken;
    logic              page_freed;
    logic [PAGE_W-1:0] freed_page;
  } rsp_t;

  // one table row as held in the memory; the valid bit lives in flops
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
    logic [PAGE_W-1:0]     page;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/rcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rcst_engine.sv
// Table engine: sweeps the entry memory, then applies one open or close.
module rcst_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  rcst_pkg::req_t req,
  output logic          req_ready,
  output logic          rsp_valid,
  output rcst_pkg::rsp_t rsp,
  input  logic          rsp_ready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  rcst_pkg::req_t   req_r;
  rcst_pkg::rsp_t   rsp_r, rsp_nxt;
  rcst_pkg::entry_t hit_r, rd_entry, wr_entry;

  logic [rcst_pkg::SCN_W-1:0]        cnt_r;
  logic [rcst_pkg::IDX_W-1:0]        cmp_idx, hit_idx_r, free_idx_r, wr_idx;
  logic                              hit_vld_r, free_vld_r;
  logic [rcst_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [rcst_pkg::ENTRY_W-1:0]      rd_data;
  logic                              rd_en, wr_en, cmp_en, scan_end;

  assign req_ready = state_r[0];
  assign rsp_valid = (state_r == S_DONE);
  assign rsp       = rsp_r;

  assign rd_en    = (state_r == S_SCAN) && (cnt_r < rcst_pkg::SCN_W'(rcst_pkg::TABLE_ENTRIES));
  assign cmp_en   = (state_r == S_SCAN) && (cnt_r != '0);
  assign scan_end = (cnt_r == rcst_pkg::SCN_W'(rcst_pkg::TABLE_ENTRIES));
  // data on the read port belongs to the entry addressed in the previous cycle
  assign cmp_idx  = rcst_pkg::IDX_W'(cnt_r - 1'b1);
  assign rd_entry = rcst_pkg::entry_t'(rd_data);

  rcst_ram #(
    .WIDTH (rcst_pkg::ENTRY_W),
    .DEPTH (rcst_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (cnt_r[rcst_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  // decision and write-back, used in S_WRITE
  always_comb begin
    rsp_nxt   = '{status: rcst_pkg::ST_FAIL, default: '0};
    wr_en     = 1'b0;
    wr_idx    = hit_idx_r;
    wr_entry  = hit_r;
    valid_nxt = valid_r;
    if (req_r.command == rcst_pkg::CMD_OPEN) begin
      if (hit_vld_r) begin
        if (hit_r.count != rcst_pkg::COUNT_MAX) begin
          wr_en            = 1'b1;
          wr_entry.count   = hit_r.count + 1'b1;
          rsp_nxt.status   = rcst_pkg::ST_OK;
          rsp_nxt.page_out = hit_r.page;
        end
      end else if (free_vld_r && req_r.spare_page_valid) begin
        wr_en               = 1'b1;
        wr_idx              = free_idx_r;
        wr_entry.key        = req_r.seg_key;
        wr_entry.count      = rcst_pkg::COUNT_BITS'(1);
        wr_entry.page       = req_r.spare_page;
        valid_nxt[free_idx_r] = 1'b1;
        rsp_nxt.status      = rcst_pkg::ST_OK;
        rsp_nxt.page_out    = req_r.spare_page;
        rsp_nxt.page_taken  = 1'b1;
      end
    end else begin
      if (hit_vld_r && (hit_r.count != '0)) begin
        wr_en          = 1'b1;
        wr_entry.count = hit_r.count - 1'b1;
        rsp_nxt.status = rcst_pkg::ST_OK;
        if (hit_r.count == rcst_pkg::COUNT_BITS'(1)) begin
          valid_nxt[hit_idx_r] = 1'b0;
          rsp_nxt.page_freed   = 1'b1;
          rsp_nxt.freed_page   = hit_r.page;
        end
      end
    end
    if (state_r != S_WRITE) begin
      wr_en     = 1'b0;
      valid_nxt = valid_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (req_valid) state_nxt = S_SCAN;
      S_SCAN:  if (scan_end) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  if (rsp_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      cnt_r      <= '0;
      hit_vld_r  <= 1'b0;
      free_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (state_r == S_IDLE) begin
        cnt_r      <= '0;
        hit_vld_r  <= 1'b0;
        free_vld_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (!scan_end) begin
          cnt_r <= cnt_r + 1'b1;
        end
        // lowest valid match and lowest free slot win
        if (cmp_en && valid_r[cmp_idx] && !hit_vld_r && (rd_entry.key == req_r.seg_key)) begin
          hit_vld_r <= 1'b1;
        end
        if (cmp_en && !valid_r[cmp_idx] && !free_vld_r) begin
          free_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req;
    end
    if (cmp_en && valid_r[cmp_idx] && !hit_vld_r && (rd_entry.key == req_r.seg_key)) begin
      hit_idx_r <= cmp_idx;
      hit_r     <= rd_entry;
    end
    if (cmp_en && !valid_r[cmp_idx] && !free_vld_r) begin
      free_idx_r <= cmp_idx;
    end
    if (state_r == S_WRITE) begin
      rsp_r <= rsp_nxt;
    end
  end

endmodule

FILE: rtl/refcounted_shared_segment_table.sv
// Top level: request word in, engine, registered result word out.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | command, seg_key, spare_page_valid, spare_page
//  out_    | output    | out_valid / out_ready| status, page_out, page_taken, page_freed,
//          |           |                      | freed_page
//
// From its acceptance a word passes through the scan (one read per entry, each compare
// following its read), the write-back state, the hand-over state and the idle state that
// takes the next word; the engine takes no new word before its result is handed over.
// Reset clears all valid bits at once; no clearing pass is needed.
// A result waiting in the output register does not hold the next word out of the engine;
// the engine only stalls at its hand-over while that register is still full.
module refcounted_shared_segment_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [rcst_pkg::KEY_W-1:0]  in_seg_key,
  input  logic                        in_spare_page_valid,
  input  logic [rcst_pkg::PAGE_W-1:0] in_spare_page,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic [rcst_pkg::PAGE_W-1:0] out_page_out,
  output logic                        out_page_taken,
  output logic                        out_page_freed,
  output logic [rcst_pkg::PAGE_W-1:0] out_freed_page
);

  rcst_pkg::req_t req;
  rcst_pkg::rsp_t eng_rsp, out_r;
  logic           eng_rsp_valid, eng_rsp_ready, out_valid_r;

  assign req = '{command:          in_command,
                 seg_key:          in_seg_key,
                 spare_page_valid: in_spare_page_valid,
                 spare_page:       in_spare_page};

  rcst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (in_ready),
    .rsp_valid (eng_rsp_valid),
    .rsp       (eng_rsp),
    .rsp_ready (eng_rsp_ready)
  );

  assign eng_rsp_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_rsp_ready) begin
      out_valid_r <= eng_rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_rsp_valid && eng_rsp_ready) begin
      out_r <= eng_rsp;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_page_out   = out_r.page_out;
  assign out_page_taken = out_r.page_taken;
  assign out_page_freed = out_r.page_freed;
  assign out_freed_page = out_r.freed_page;

  // a failed request leaves nothing behind
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_page_out == '0) && !out_page_taken && !out_page_freed && (out_freed_page == '0))
    else $error("failed result carries page data");

  // an open never frees and a close never takes
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_page_taken && out_page_freed))
    else $error("result both takes and frees a page");

  // engine offers no result while it is taking a request
  a_engine_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !eng_rsp_valid)
    else $error("engine idle with a result pending");

  // after an accepted request, no request is taken in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine accepted back-to-back words");

endmodule

FILE: sim/refcounted_shared_segment_table_tb.sv
// Self-checking testbench for the shared segment table: predicts every result word and compares.
module refcounted_shared_segment_table_tb;

  localparam int LIMIT_CYCLES = 600000;
  localparam int POOL_SIZE    = 24;

  logic clk = 1'b0;
  logic rst_n;

  logic                        in_valid;
  logic                        in_ready;
  logic                        in_command;
  logic [rcst_pkg::KEY_W-1:0]  in_seg_key;
  logic                        in_spare_page_valid;
  logic [rcst_pkg::PAGE_W-1:0] in_spare_page;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_status;
  logic [rcst_pkg::PAGE_W-1:0] out_page_out;
  logic                        out_page_taken;
  logic                        out_page_freed;
  logic [rcst_pkg::PAGE_W-1:0] out_freed_page;

  // shadow copy of the segment table
  logic                            seg_live  [rcst_pkg::TABLE_ENTRIES];
  logic [rcst_pkg::KEY_W-1:0]      seg_key   [rcst_pkg::TABLE_ENTRIES];
  logic [rcst_pkg::COUNT_BITS-1:0] seg_refs  [rcst_pkg::TABLE_ENTRIES];
  logic [rcst_pkg::PAGE_W-1:0]     seg_page  [rcst_pkg::TABLE_ENTRIES];

  rcst_pkg::rsp_t pending_rsp_q[$];

  int  err_cnt;
  int  cycle_cnt;
  int  n_sent;
  int  n_checked;
  int  n_refused;
  int  n_freed;
  bit  send_idle;
  bit  recv_idle;
  int  hold_req;

  refcounted_shared_segment_table u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_seg_key          (in_seg_key),
    .in_spare_page_valid (in_spare_page_valid),
    .in_spare_page       (in_spare_page),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_page_out        (out_page_out),
    .out_page_taken      (out_page_taken),
    .out_page_freed      (out_page_freed),
    .out_freed_page      (out_freed_page)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow table and returns the result word it gives.
  function automatic rcst_pkg::rsp_t apply_segment_request(rcst_pkg::req_t r);
    rcst_pkg::rsp_t res;
    int   hit;
    int   spare;
    int   i;
    res        = '0;
    res.status = rcst_pkg::ST_FAIL;
    hit        = -1;
    spare      = -1;
    // scan downwards so the lowest index wins for both searches
    for (i = rcst_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (seg_live[i] && seg_key[i] == r.seg_key) hit = i;
      if (!seg_live[i]) spare = i;
    end
    if (r.command == rcst_pkg::CMD_OPEN) begin
      if (hit >= 0) begin
        if (seg_refs[hit] != rcst_pkg::COUNT_MAX) begin
          seg_refs[hit] = seg_refs[hit] + 1'b1;
          res.status    = rcst_pkg::ST_OK;
          res.page_out  = seg_page[hit];
        end
      end else if (spare >= 0 && r.spare_page_valid) begin
        seg_live[spare] = 1'b1;
        seg_key[spare]  = r.seg_key;
        seg_refs[spare] = rcst_pkg::COUNT_BITS'(1);
        seg_page[spare] = r.spare_page;
        res.status      = rcst_pkg::ST_OK;
        res.page_out    = r.spare_page;
        res.page_taken  = 1'b1;
      end
    end else begin
      if (hit >= 0 && seg_refs[hit] != '0) begin
        seg_refs[hit] = seg_refs[hit] - 1'b1;
        res.status    = rcst_pkg::ST_OK;
        if (seg_refs[hit] == '0) begin
          seg_live[hit]  = 1'b0;
          res.page_freed = 1'b1;
          res.freed_page = seg_page[hit];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("tb: mismatch in %s at result %0d: got %0h, predicted %0h",
             what, n_checked, got, want);
  endtask

  // Offers one request word and waits for it to be taken.
  task automatic send_request(input logic cmd, input logic [rcst_pkg::KEY_W-1:0] key,
                              input logic offer, input logic [rcst_pkg::PAGE_W-1:0] page);
    int             gap;
    rcst_pkg::req_t r;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_seg_key          <= key;
    in_spare_page_valid <= offer;
    in_spare_page       <= page;
    do @(posedge clk); while (!in_ready);
    r.command          = cmd;
    r.seg_key          = key;
    r.spare_page_valid = offer;
    r.spare_page       = page;
    pending_rsp_q.push_back(apply_segment_request(r));
    n_sent++;
  endtask

  task automatic wait_drained();
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Extremes of key and page, key zero as an ordinary key, reuse of the lowest free entry.
  task automatic test_basic_ops();
    send_request(rcst_pkg::CMD_OPEN,  32'h0000_0000, 1'b1, 20'hFFFFF);
    send_request(rcst_pkg::CMD_OPEN,  32'h0000_0000, 1'b0, 20'h12345);  // existing: no page
    send_request(rcst_pkg::CMD_OPEN,  32'hFFFF_FFFF, 1'b0, 20'h00000);  // new, no page: fails
    send_request(rcst_pkg::CMD_OPEN,  32'hFFFF_FFFF, 1'b1, 20'h00000);
    send_request(rcst_pkg::CMD_CLOSE, 32'h0000_0001, 1'b1, 20'h54321);  // absent key
    send_request(rcst_pkg::CMD_CLOSE, 32'h0000_0000, 1'b0, 20'h00000);
    send_request(rcst_pkg::CMD_CLOSE, 32'h0000_0000, 1'b0, 20'h00000);  // releases the page
    send_request(rcst_pkg::CMD_CLOSE, 32'h0000_0000, 1'b1, 20'hFFFFF);
    send_request(rcst_pkg::CMD_OPEN,  32'h5A5A_5A5A, 1'b1, 20'hAAAAA);  // takes entry 0 again
    send_request(rcst_pkg::CMD_CLOSE, 32'hFFFF_FFFF, 1'b1, 20'h0F0F0);
    send_request(rcst_pkg::CMD_CLOSE, 32'h5A5A_5A5A, 1'b0, 20'h00000);
    send_request(rcst_pkg::CMD_OPEN,  32'h8000_0000, 1'b1, 20'h55555);
    send_request(rcst_pkg::CMD_CLOSE, 32'h8000_0000, 1'b1, 20'hFFFFF);
  endtask

  // Fill every entry, refuse one more, free a middle entry and claim it back.
  task automatic test_table_full();
    int i;
    for (i = 0; i < rcst_pkg::TABLE_ENTRIES; i++)
      send_request(rcst_pkg::CMD_OPEN, 32'h5E60_0000 | i, 1'b1, rcst_pkg::PAGE_W'($urandom));
    // no free entry
    send_request(rcst_pkg::CMD_OPEN,  32'h7777_7777, 1'b1, rcst_pkg::PAGE_W'($urandom));
    send_request(rcst_pkg::CMD_OPEN,  32'h5E60_0003, 1'b0, '0);
    send_request(rcst_pkg::CMD_CLOSE, 32'h5E60_0003, 1'b0, '0);
    send_request(rcst_pkg::CMD_CLOSE, 32'h5E60_0005, 1'b0, '0);
    send_request(rcst_pkg::CMD_OPEN,  32'h7777_7777, 1'b1, rcst_pkg::PAGE_W'($urandom));
    send_request(rcst_pkg::CMD_CLOSE, 32'h5E60_0003, 1'b0, '0);
    for (i = 0; i < rcst_pkg::TABLE_ENTRIES; i++)
      if (i != 5) send_request(rcst_pkg::CMD_CLOSE, 32'h5E60_0000 | i, 1'b0, '0);
    send_request(rcst_pkg::CMD_CLOSE, 32'h7777_7777, 1'b0, '0);
  endtask

  // Count one segment up to its ceiling, push past it, then close it all the way down.
  task automatic test_count_saturation();
    int i;
    send_request(rcst_pkg::CMD_OPEN, 32'hA5A5_0001, 1'b1, rcst_pkg::PAGE_W'($urandom));
    for (i = 1; i < int'(rcst_pkg::COUNT_MAX); i++)
      send_request(rcst_pkg::CMD_OPEN, 32'hA5A5_0001, 1'($urandom_range(0, 1)),
                   rcst_pkg::PAGE_W'($urandom));
    send_request(rcst_pkg::CMD_OPEN, 32'hA5A5_0001, 1'b1, rcst_pkg::PAGE_W'($urandom));
    send_request(rcst_pkg::CMD_OPEN, 32'hA5A5_0001, 1'b0, rcst_pkg::PAGE_W'($urandom));
    for (i = 0; i < int'(rcst_pkg::COUNT_MAX); i++)
      send_request(rcst_pkg::CMD_CLOSE, 32'hA5A5_0001, 1'($urandom_range(0, 1)),
                   rcst_pkg::PAGE_W'($urandom));
    send_request(rcst_pkg::CMD_CLOSE, 32'hA5A5_0001, 1'b1, rcst_pkg::PAGE_W'($urandom));
  endtask

  // Long receiver hold-off while words keep coming back to back.
  task automatic test_output_backpressure();
    int i;
    send_idle = 1'b0;
    hold_req  = 400;
    for (i = 0; i < 20; i++)
      send_request((i % 3 == 2) ? rcst_pkg::CMD_CLOSE : rcst_pkg::CMD_OPEN,
                   32'hB000_0000 | (i % 4), 1'b1, rcst_pkg::PAGE_W'($urandom));
    for (i = 0; i < 4; i++)
      repeat (2) send_request(rcst_pkg::CMD_CLOSE, 32'hB000_0000 | i, 1'b0, '0);
  endtask

  // Mostly keys from a small pool so segments are shared and the table churns.
  task automatic test_random_traffic(input int count);
    logic [rcst_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    logic [rcst_pkg::KEY_W-1:0] key;
    logic                       cmd;
    int                         i;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      cmd = ($urandom_range(0, 99) < 55) ? rcst_pkg::CMD_OPEN : rcst_pkg::CMD_CLOSE;
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(cmd, key, $urandom_range(0, 9) != 0, rcst_pkg::PAGE_W'($urandom));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rcst_pkg::rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unrequested result word", {31'b0, out_status}, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_status != want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_page_out != want.page_out)
          report_mismatch("page_out", 32'(out_page_out), 32'(want.page_out));
        if (out_page_taken != want.page_taken)
          report_mismatch("page_taken", 32'(out_page_taken), 32'(want.page_taken));
        if (out_page_freed != want.page_freed)
          report_mismatch("page_freed", 32'(out_page_freed), 32'(want.page_freed));
        if (out_freed_page != want.freed_page)
          report_mismatch("freed_page", 32'(out_freed_page), 32'(want.freed_page));
      end
      n_checked++;
      if (out_status == rcst_pkg::ST_FAIL) n_refused++;
      if (out_page_freed) n_freed++;
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_cycles;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        stall_cycles = hold_req;
        hold_req     = 0;
      end else begin
        stall_cycles = recv_idle ? $urandom_range(0, 6) : 0;
      end
      if (stall_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (stall_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && hold_req == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < rcst_pkg::TABLE_ENTRIES; i++) begin
      seg_live[i] = 1'b0;
      seg_key[i]  = '0;
      seg_refs[i] = '0;
      seg_page[i] = '0;
    end
    err_cnt             = 0;
    cycle_cnt           = 0;
    n_sent              = 0;
    n_checked           = 0;
    n_refused           = 0;
    n_freed             = 0;
    hold_req            = 0;
    send_idle           = 1'b1;
    recv_idle           = 1'b1;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_command          = rcst_pkg::CMD_OPEN;
    in_seg_key          = '0;
    in_spare_page_valid = 1'b0;
    in_spare_page       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_table_full();
    test_count_saturation();
    test_output_backpressure();
    send_idle = 1'b1;
    test_random_traffic(800);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("tb: %0d request words sent, %0d result words checked", n_sent, n_checked);
    $display("tb: %0d refused, %0d pages released; full table and count ceiling covered",
             n_refused, n_freed);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
